// ----- rtl/core/icl_pkg.sv -----
// ----------------------------------------------------------------------------
// icl_pkg
// Types and constants shared by the init command list player modules.
// ----------------------------------------------------------------------------
package icl_pkg;

   // result kinds; a queued job carries the kind it expands into
   typedef enum logic [1:0] {
      KIND_FRAME = 2'd0,
      KIND_PARAM = 2'd1,
      KIND_DELAY = 2'd2,
      KIND_END   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] wait_ms;
   } job_type;

   // table parser phases
   localparam logic [1:0] PH_CMD    = 2'd0;
   localparam logic [1:0] PH_COUNT  = 2'd1;
   localparam logic [1:0] PH_PARAMS = 2'd2;
   localparam logic [1:0] PH_DELAY  = 2'd3;

   localparam logic [7:0]  END_MARK         = 8'hFF;
   localparam logic [7:0]  LONG_DELAY_CODE  = 8'd255;
   localparam logic [15:0] LONG_DELAY_RESET = 16'd500;
   localparam logic [7:0]  FRAME_OPCODE     = 8'h02;
   localparam logic [7:0]  FRAME_PAD        = 8'h00;

   localparam logic [1:0]  BEAT_LAST        = 2'd3;

   localparam int          QDEPTH           = 4;
   localparam int          QPTR_W           = $clog2(QDEPTH);
   localparam int          QCNT_W           = $clog2(QDEPTH + 1);

endpackage

// ----- rtl/core/icl_if.sv -----
// ----------------------------------------------------------------------------
// icl channel interfaces
// Valid/ready channels for table bytes, results and the delay register write.
// ----------------------------------------------------------------------------
interface icl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] table_byte;

   modport source (output valid, output table_byte, input ready);
   modport sink   (input valid, input table_byte, output ready);
endinterface

interface icl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  out_byte;
   logic [15:0] wait_ms;
   logic        frame_start;
   logic        last;

   modport source (output valid, output kind, output out_byte, output wait_ms,
                   output frame_start, output last, input ready);
   modport sink   (input valid, input kind, input out_byte, input wait_ms,
                   input frame_start, input last, output ready);
endinterface

interface icl_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/icl_front.sv -----
// ----------------------------------------------------------------------------
// icl_front
// Table parser: takes one table byte per cycle while the job queue is not full,
// and queues one job per byte that produces output.
// ----------------------------------------------------------------------------
module icl_front #(
   parameter int DELAY_FLAG_MASK = 128
) (
   input  logic             clock,
   input  logic             reset,
   icl_req_if.sink          req,
   icl_csr_if.sink          csr,
   output logic             push_valid,
   output icl_pkg::job_type push_job,
   input  logic             q_full
);
   import icl_pkg::*;

   localparam logic [7:0] FlagMask = 8'(DELAY_FLAG_MASK);
   localparam int         CntMax   = 255 & ~DELAY_FLAG_MASK;
   localparam int         CntW     = (CntMax < 2) ? 1 : $clog2(CntMax + 1);

   logic [1:0]      phase_ff, phase_in;
   logic [7:0]      held_ff, held_in;
   logic [CntW-1:0] left_ff, left_in;
   logic            dly_ff, dly_in;
   logic [15:0]     long_delay_ff;
   logic            accept;
   logic [7:0]      b;
   logic [CntW-1:0] count;
   logic            flag;

   assign req.ready = !q_full;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;
   assign b         = req.table_byte;
   assign count     = CntW'(b & ~FlagMask);
   assign flag      = (b & FlagMask) != 8'd0;

   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      left_in    = left_ff;
      dly_in     = dly_ff;
      push_valid = 1'b0;
      push_job   = '{kind: KIND_PARAM, data: b, wait_ms: 16'd0};
      if (accept) begin
         unique case (phase_ff)
            PH_COUNT: begin
               push_valid = 1'b1;
               if (held_ff == END_MARK && b == END_MARK) begin
                  push_job = '{kind: KIND_END, data: 8'd0, wait_ms: 16'd0};
                  phase_in = PH_CMD;
                  left_in  = '0;
                  dly_in   = 1'b0;
               end else begin
                  push_job = '{kind: KIND_FRAME, data: held_ff, wait_ms: 16'd0};
                  dly_in   = flag;
                  left_in  = count;
                  if (count != '0) phase_in = PH_PARAMS;
                  else             phase_in = flag ? PH_DELAY : PH_CMD;
               end
            end
            PH_PARAMS: begin
               push_valid = 1'b1;
               left_in    = left_ff - CntW'(1);
               // last parameter: move on to the delay byte or the next command
               if (left_ff <= CntW'(1)) phase_in = dly_ff ? PH_DELAY : PH_CMD;
            end
            PH_DELAY: begin
               push_valid = 1'b1;
               push_job   = '{kind: KIND_DELAY, data: 8'd0,
                              wait_ms: (b == LONG_DELAY_CODE) ? long_delay_ff
                                                              : {8'd0, b}};
               dly_in     = 1'b0;
               phase_in   = PH_CMD;
            end
            PH_CMD: begin
               held_in  = b;
               phase_in = PH_COUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_CMD;
         held_ff       <= 8'd0;
         left_ff       <= '0;
         dly_ff        <= 1'b0;
         long_delay_ff <= LONG_DELAY_RESET;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         left_ff  <= left_in;
         dly_ff   <= dly_in;
         if (csr.valid) long_delay_ff <= csr.data;
      end
   end

endmodule

// ----- rtl/core/icl_queue.sv -----
// ----------------------------------------------------------------------------
// icl_queue
// Short job FIFO between the parser and the frame expander.
// ----------------------------------------------------------------------------
module icl_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  icl_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output icl_pkg::job_type head
);
   import icl_pkg::*;

   job_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              do_push, do_pop;

   assign full    = cnt_ff == QCNT_W'(QDEPTH);
   assign empty   = cnt_ff == '0;
   assign head    = slot_ff[rd_ff];
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + QPTR_W'(1);
         if (do_pop)  rd_ff <= rd_ff + QPTR_W'(1);
         if (do_push && !do_pop)      cnt_ff <= cnt_ff + QCNT_W'(1);
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - QCNT_W'(1);
      end
   end

endmodule

// ----- rtl/core/icl_back.sv -----
// ----------------------------------------------------------------------------
// icl_back
// Frame expander: turns queued jobs into result transfers through a
// registered output stage.
// ----------------------------------------------------------------------------
module icl_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  icl_pkg::job_type head,
   output logic             pop,
   icl_rsp_if.source        rsp
);
   import icl_pkg::*;

   logic [1:0]  beat_ff;
   logic        valid_ff;
   logic [1:0]  kind_ff;
   logic [7:0]  byte_ff;
   logic [15:0] wait_ff;
   logic        start_ff;
   logic        last_ff;
   logic        load;
   logic        is_frame;
   logic [7:0]  frame_byte;

   assign load     = !empty && (!valid_ff || rsp.ready);
   assign is_frame = head.kind == KIND_FRAME;
   assign pop      = load && (!is_frame || beat_ff == BEAT_LAST);

   // command frame: opcode, pad, command, pad
   always_comb begin
      unique case (beat_ff)
         2'd0:    frame_byte = FRAME_OPCODE;
         2'd2:    frame_byte = head.data;
         default: frame_byte = FRAME_PAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= 2'd0;
      end else begin
         if (load) valid_ff <= 1'b1;
         else if (rsp.ready) valid_ff <= 1'b0;
         if (load && is_frame) beat_ff <= beat_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= head.kind;
         byte_ff  <= is_frame ? frame_byte : head.data;
         wait_ff  <= head.wait_ms;
         start_ff <= is_frame && beat_ff == 2'd0;
         last_ff  <= !is_frame || beat_ff == BEAT_LAST;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.kind        = kind_ff;
   assign rsp.out_byte    = byte_ff;
   assign rsp.wait_ms     = wait_ff;
   assign rsp.frame_start = start_ff;
   assign rsp.last        = last_ff;

endmodule

// ----- rtl/core/init_command_list_player.sv -----
// ----------------------------------------------------------------------------
// init_command_list_player
// Plays a display init table as command frames, parameter bytes and delays.
// ----------------------------------------------------------------------------
// The parser takes one table byte per clock whenever the four-entry job queue
// has room; a command byte only is held, other bytes each queue one job. The
// expander drains one job per clock through a registered output while the
// result side is ready, except a command frame, which yields one result per
// frame byte. Throughput is therefore set by the expander: an entry of
// command, count and N parameter bytes (plus an optional delay byte) yields
// 4 + N (+1) results. Results are loaded into the output register from the
// queue head when that register is empty or being taken. The delay register
// may be written at any time the block is idle; csr.ready is always high.
// ----------------------------------------------------------------------------
module init_command_list_player #(
   parameter int DELAY_FLAG_MASK = 128
) (
   input  logic      clock,
   input  logic      reset,
   icl_req_if.sink   req,
   icl_rsp_if.source rsp,
   icl_csr_if.sink   csr
);
   import icl_pkg::*;

   logic    push_valid;
   job_type push_job;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   job_type q_head;

   icl_front #(
      .DELAY_FLAG_MASK(DELAY_FLAG_MASK)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr        (csr),
      .push_valid (push_valid),
      .push_job   (push_job),
      .q_full     (q_full)
   );

   icl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   icl_back u_back (
      .clock (clock),
      .reset (reset),
      .empty (q_empty),
      .head  (q_head),
      .pop   (q_pop),
      .rsp   (rsp)
   );

endmodule

// ----- verif/init_command_list_checker.sv -----
// ----------------------------------------------------------------------------
// init_command_list_checker
// Watches the table byte, result and delay register channels of the init
// command list player. It tracks the table parser itself, queues the results
// each accepted byte should produce, and compares every result transfer
// against the oldest queued result.
// ----------------------------------------------------------------------------
module init_command_list_checker #(
   parameter int DELAY_FLAG_MASK = 128
) (
   input  logic clock,
   input  logic reset,
   icl_req_if   req,
   icl_rsp_if   rsp,
   icl_csr_if   csr,
   output int   mismatches,
   output int   pending,
   output int   checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import icl_pkg::*;

   localparam logic [7:0] FLAG_BITS = 8'(DELAY_FLAG_MASK);
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  out_byte;
      logic [15:0] wait_ms;
      logic        frame_start;
      logic        last;
   } play_result_type;

   play_result_type expected_results[$];

   logic [1:0]  parse_phase;
   logic [7:0]  held_cmd;
   logic [7:0]  params_left;
   logic        delay_pending;
   logic [15:0] long_delay;

   function automatic play_result_type make_result(input kind_type k, input logic [7:0] b,
                                                   input logic [15:0] w, input logic s,
                                                   input logic l);
      play_result_type r;
      r.kind        = k;
      r.out_byte    = b;
      r.wait_ms     = w;
      r.frame_start = s;
      r.last        = l;
      return r;
   endfunction

   task automatic predict_table_byte(input logic [7:0] b);
      case (parse_phase)
         PH_COUNT: begin
            if (held_cmd == END_MARK && b == END_MARK) begin
               expected_results.push_back(make_result(KIND_END, 8'h00, 16'h0000, 1'b0, 1'b1));
               parse_phase   = PH_CMD;
               params_left   = '0;
               delay_pending = 1'b0;
            end else begin
               expected_results.push_back(make_result(KIND_FRAME, FRAME_OPCODE, 16'h0000,
                                                      1'b1, 1'b0));
               expected_results.push_back(make_result(KIND_FRAME, FRAME_PAD, 16'h0000,
                                                      1'b0, 1'b0));
               expected_results.push_back(make_result(KIND_FRAME, held_cmd, 16'h0000,
                                                      1'b0, 1'b0));
               expected_results.push_back(make_result(KIND_FRAME, FRAME_PAD, 16'h0000,
                                                      1'b0, 1'b1));
               delay_pending = (b & FLAG_BITS) != 8'h00;
               params_left   = b & ~FLAG_BITS;
               if (params_left != 8'h00) begin
                  parse_phase = PH_PARAMS;
               end else begin
                  parse_phase = delay_pending ? PH_DELAY : PH_CMD;
               end
            end
         end
         PH_PARAMS: begin
            expected_results.push_back(make_result(KIND_PARAM, b, 16'h0000, 1'b0, 1'b1));
            if (params_left != 8'h00) params_left = params_left - 8'd1;
            if (params_left == 8'h00) parse_phase = delay_pending ? PH_DELAY : PH_CMD;
         end
         PH_DELAY: begin
            // delay code 255 stands for the programmable long delay
            expected_results.push_back(make_result(KIND_DELAY, 8'h00,
                                                   (b == LONG_DELAY_CODE) ? long_delay
                                                                          : {8'h00, b},
                                                   1'b0, 1'b1));
            delay_pending = 1'b0;
            parse_phase   = PH_CMD;
         end
         default: begin
            held_cmd    = b;
            parse_phase = PH_COUNT;
         end
      endcase
   endtask

   task automatic check_result(input play_result_type got);
      play_result_type want;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: result with nothing expected:", $realtime,
                     " kind=%0d byte=%02h wait=%0d start=%0b last=%0b",
                     got.kind, got.out_byte, got.wait_ms, got.frame_start, got.last);
         return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
          got.wait_ms !== want.wait_ms || got.frame_start !== want.frame_start ||
          got.last !== want.last) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: result mismatch", $realtime);
            $display("   expected kind=%0d byte=%02h wait=%0d start=%0b last=%0b",
                     want.kind, want.out_byte, want.wait_ms, want.frame_start, want.last);
            $display("   actual   kind=%0d byte=%02h wait=%0d start=%0b last=%0b",
                     got.kind, got.out_byte, got.wait_ms, got.frame_start, got.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         parse_phase   = PH_CMD;
         held_cmd      = '0;
         params_left   = '0;
         delay_pending = 1'b0;
         long_delay    = LONG_DELAY_RESET;
         mismatches    = 0;
         checked       = 0;
      end else begin
         // results leaving now belong to bytes taken on earlier edges
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            check_result(make_result(kind_type'(rsp.kind), rsp.out_byte, rsp.wait_ms,
                                     rsp.frame_start, rsp.last));
         if (csr.valid === 1'b1 && csr.ready === 1'b1) long_delay = csr.data;
         if (req.valid === 1'b1 && req.ready === 1'b1) predict_table_byte(req.table_byte);
      end
      pending = expected_results.size();
   end

endmodule

// ----- verif/init_command_list_player_test.sv -----
// ----------------------------------------------------------------------------
// init_command_list_player_test
// Drives init tables into the player: a directed list covering every result
// kind and the count and delay corner cases, then random lists with broken
// entries under several long-delay settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module init_command_list_player_test;
   timeunit 1ns;
   timeprecision 1ps;

   import icl_pkg::*;

   localparam int         FLAG_MASK     = 128;
   localparam logic [7:0] FLAG_BIT      = 8'(FLAG_MASK);
   localparam int         ITEM_TARGET   = 420;
   localparam int         SETTLE_CYCLES = 16;
   localparam int         QUIET_LIMIT   = 1000;

   logic clock;
   logic reset;

   icl_req_if req ();
   icl_rsp_if rsp ();
   icl_csr_if csr ();

   int mismatches;
   int pending;
   int checked;
   int bytes_sent;
   int settings_used;
   int quiet = 0;
   int stall_left;
   int directed_bytes;
   bit calm;

   init_command_list_player #(
      .DELAY_FLAG_MASK(FLAG_MASK)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   init_command_list_checker #(
      .DELAY_FLAG_MASK(FLAG_MASK)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .csr        (csr),
      .mismatches (mismatches),
      .pending    (pending),
      .checked    (checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: random stall bursts unless in the calm stretch
   initial begin
      rsp.ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp.ready <= 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1) ||
          (csr.valid === 1'b1 && csr.ready === 1'b1)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
         $display("** init_command_list_player: FAILED **");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req.valid      <= 1'b1;
      req.table_byte <= b;
      @(posedge clock);
      while (req.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // wait for every queued result, then let the parser settle
   task automatic drain();
      req.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_long_delay(input logic [15:0] v);
      csr.valid <= 1'b1;
      csr.data  <= v;
      @(posedge clock);
      while (csr.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
      csr.valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [7:0] pick_delay();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return LONG_DELAY_CODE;
         2:       return 8'hFE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_entry(input logic [7:0] cmd, input logic [7:0] count);
      int n;
      n = int'(count & ~FLAG_BIT);
      send_byte(cmd);
      send_byte(count);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
      if ((count & FLAG_BIT) != 8'h00) send_byte(pick_delay());
   endtask

   task automatic send_random_entry();
      logic [7:0] cmd;
      logic [6:0] n;
      cmd = ($urandom_range(0, 7) == 0) ? END_MARK : 8'($urandom_range(0, 255));
      n   = ($urandom_range(0, 6) == 0) ? 7'($urandom_range(5, 12)) : 7'($urandom_range(0, 4));
      send_entry(cmd, ($urandom_range(0, 1) ? FLAG_BIT : 8'h00) | {1'b0, n});
   endtask

   // malformed table fragments; the parser just keeps counting
   task automatic send_noise();
      int n;
      case ($urandom_range(0, 2))
         0: begin
            n = $urandom_range(2, 4);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'(n));
            repeat ($urandom_range(0, n - 1)) send_byte(8'($urandom_range(0, 255)));
         end
         1: send_byte(END_MARK);
         default: repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic send_end();
      send_byte(END_MARK);
      send_byte(END_MARK);
   endtask

   task automatic play_random_list();
      repeat ($urandom_range(1, 4)) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         else send_random_entry();
      end
      send_end();
   endtask

   initial begin
      reset          = 1'b1;
      req.valid      = 1'b0;
      req.table_byte = 8'h00;
      csr.valid      = 1'b0;
      csr.data       = 16'h0000;
      calm           = 1'b0;
      bytes_sent     = 0;
      settings_used  = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed list at the reset long delay
      send_entry(8'h00, 8'h00);
      send_byte(END_MARK);               // 0xFF command with an ordinary count
      send_byte(FLAG_BIT | 8'h01);
      send_byte(8'h00);
      send_byte(LONG_DELAY_CODE);
      send_byte(8'hA5);                  // zero count, delay follows at once
      send_byte(FLAG_BIT);
      send_byte(8'h00);
      send_byte(8'h3C);
      send_byte(8'h02);
      send_byte(8'hFF);
      send_byte(8'h55);
      send_byte(8'h11);
      send_byte(FLAG_BIT);
      send_byte(8'hFE);
      send_end();
      send_byte(8'h5A);                  // second list after the end marker
      send_byte(8'h01);
      send_byte(8'h80);
      send_end();
      drain();
      directed_bytes = bytes_sent;

      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       set_long_delay(16'h0000);
            1:       set_long_delay(16'hFFFF);
            default: set_long_delay(16'($urandom_range(1, 65534)));
         endcase
         calm = (p == 3);
         if (p == 1) begin
            send_entry(8'h7E, 8'hFF);    // widest count, with delay
            send_end();
         end
         while (bytes_sent < directed_bytes + (p + 1) * ITEM_TARGET / 4) play_random_list();
         drain();
      end

      $display("Sent %0d table bytes under %0d long-delay settings plus the reset value;",
               bytes_sent, settings_used);
      $display("%0d results compared, %0d mismatches.", checked, mismatches);
      if (mismatches == 0) begin
         $display("** init_command_list_player: PASSED **");
      end else begin
         $display("** init_command_list_player: FAILED **");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/icl_pkg.sv
rtl/core/icl_if.sv
rtl/core/icl_front.sv
rtl/core/icl_queue.sv
rtl/core/icl_back.sv
rtl/core/init_command_list_player.sv
verif/init_command_list_checker.sv
verif/init_command_list_player_test.sv
